>>> hw/rtl/buck_rail_voltage_select_regs_assert.svh
// assertion macros for the rail voltage-select register bank
`ifndef BUCK_RAIL_VOLTAGE_SELECT_REGS_ASSERT_SVH
`define BUCK_RAIL_VOLTAGE_SELECT_REGS_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define BRVS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("brvs check failed");

// next-cycle implication
`define BRVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("brvs check failed");

`endif

>>> hw/rtl/brvs_pkg.sv
package brvs_pkg;

  // bank geometry
  localparam int NUM_RAILS = 8;
  localparam int CODE_BITS = 7;

  // field widths
  localparam int KIND_W   = 2;
  localparam int RAIL_W   = 3;
  localparam int SEL_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int UV_W     = 22;
  localparam int MIN_W    = 21;
  localparam int STEP_W   = 17;
  localparam int MASK_W   = 8;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 21;

  // divider and multiplier sizing
  localparam int DIV_STEPS = UV_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int PROD_W    = STEP_W + BYTE_W;
  localparam int BASE_W    = PROD_W + 1;
  localparam int DBL_W     = BASE_W + 1;

  // code and voltage constants
  localparam logic [BYTE_W-1:0] CODE_MASK  = BYTE_W'((1 << CODE_BITS) - 1);
  localparam logic [BYTE_W-1:0] CODE_FLOOR = 8'h06;
  localparam logic [BYTE_W-1:0] CODE_HIGH  = 8'h79;
  localparam logic [BYTE_W-1:0] CODE_TOP   = (8'h78 < CODE_MASK) ? 8'h78 : CODE_MASK;
  localparam logic [BYTE_W-1:0] CTL_PIN_CLR = 8'hBF;
  localparam logic [BYTE_W-1:0] FORCE_CODE_MASK = 8'h7F;
  localparam logic [UV_W-1:0]   UV_HIGH_CODE = 22'd1650000;
  localparam logic [UV_W-1:0]   VMAX_UV      = 22'd3300000;

  // config reset values
  localparam logic [MIN_W-1:0]  MIN_RST  = 21'd500000;
  localparam logic [STEP_W-1:0] STEP_RST = 17'd10000;
  localparam logic [MASK_W-1:0] MASK_RST = 8'd45;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_SET   = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  typedef enum logic [SEL_W-1:0] {
    SEL_CTRL  = 2'd0,
    SEL_FORCE = 2'd1,
    SEL_VOLT  = 2'd2,
    SEL_RSVD  = 2'd3
  } sel_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_OFF    = 2'd1,
    ST_PIN    = 2'd2,
    ST_NO_REG = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN  = 2'd0,
    CFG_STEP = 2'd1,
    CFG_MASK = 2'd2
  } cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic apply;
    logic mul;
    logic finish;
  } brvs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_is_set;
    logic out_free;
  } brvs_sts_t;

endpackage

>>> hw/rtl/brvs_ctrl.sv
module brvs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  brvs_pkg::brvs_sts_t sts_i,
  output brvs_pkg::brvs_cmd_t cmd_o
);
  import brvs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_APPLY,
    S_MUL,
    S_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_IDLE);

  // sequencing of one transaction
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = sts_i.in_is_set ? S_DIV : S_APPLY;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> hw/rtl/brvs_dp.sv
module brvs_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [brvs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [brvs_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic [brvs_pkg::KIND_W-1:0]       kind_i,
  input  logic [brvs_pkg::RAIL_W-1:0]       rail_i,
  input  logic [brvs_pkg::SEL_W-1:0]        reg_select_i,
  input  logic [brvs_pkg::BYTE_W-1:0]       write_data_i,
  input  logic [brvs_pkg::UV_W-1:0]         target_uv_i,
  input  logic                              out_ready_i,
  input  brvs_pkg::brvs_cmd_t               cmd_i,
  output brvs_pkg::brvs_sts_t               sts_o,
  output logic                              out_valid_o,
  output logic [brvs_pkg::BYTE_W-1:0]       read_data_o,
  output logic [brvs_pkg::STAT_W-1:0]       status_o,
  output logic [brvs_pkg::BYTE_W-1:0]       effective_code_o,
  output logic [brvs_pkg::UV_W-1:0]         voltage_uv_o
);
  import brvs_pkg::*;

  // configuration
  logic [MIN_W-1:0]  min_q;
  logic [STEP_W-1:0] step_q;
  logic [MASK_W-1:0] mask_q;

  // register bank
  logic [BYTE_W-1:0] ctrl_q  [NUM_RAILS];
  logic [BYTE_W-1:0] force_q [NUM_RAILS];
  logic [BYTE_W-1:0] volt_q  [NUM_RAILS];

  // latched transaction
  logic [KIND_W-1:0] kind_q;
  logic [RAIL_W-1:0] rail_q;
  logic [SEL_W-1:0]  sel_q;
  logic [BYTE_W-1:0] wd_q;
  logic              below_q;

  // divider
  logic [UV_W-1:0]   dq_q;
  logic [STEP_W-1:0] rem_q;
  logic [STEP_W:0]   rem_sh;
  logic [STEP_W+1:0] diff;

  // access results
  logic              bad_q, oor_q;
  logic [BYTE_W-1:0] rd_q;
  logic [BYTE_W-1:0] eff_q;
  status_e           st_q;
  logic [PROD_W-1:0] prod_q;

  // output register
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_rd_q, out_code_q;
  logic [STAT_W-1:0] out_st_q;
  logic [UV_W-1:0]   out_uv_q;

  // combinational views of the addressed rail
  logic [BYTE_W-1:0] ctl_cur, frc_cur, vlt_cur, reg_byte, src, eff, code_set, vcode, fv;
  logic              has_force, reg_ok, rail_ok, rail_on;
  status_e           rail_st;
  logic [BASE_W-1:0] base;
  logic [DBL_W-1:0]  dbl;

  assign sts_o.in_is_set = (kind_i == KIND_SET);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // rail decode and effective code
  always_comb begin
    ctl_cur   = ctrl_q[rail_q];
    frc_cur   = force_q[rail_q];
    vlt_cur   = volt_q[rail_q];
    has_force = mask_q[rail_q];
    rail_ok   = (5'(rail_q) < 5'(NUM_RAILS));
    rail_on   = (ctl_cur[5:4] != 2'b00);
    if (!rail_on) begin
      rail_st = ST_OFF;
    end else if (ctl_cur[6]) begin
      rail_st = ST_PIN;
    end else begin
      rail_st = ST_OK;
    end
    src = (has_force && !frc_cur[7]) ? frc_cur : vlt_cur;
    eff = (rail_st != ST_OK) ? '0 : ((src & CODE_MASK) | {vlt_cur[7], 7'b0});
    case (sel_q)
      SEL_CTRL: begin
        reg_ok   = 1'b1;
        reg_byte = ctl_cur;
      end
      SEL_FORCE: begin
        reg_ok   = has_force;
        reg_byte = frc_cur;
      end
      SEL_VOLT: begin
        reg_ok   = 1'b1;
        reg_byte = vlt_cur;
      end
      default: begin
        reg_ok   = 1'b0;
        reg_byte = '0;
      end
    endcase
  end

  // set code from the quotient, saturated to the legal window
  always_comb begin
    if (below_q) begin
      code_set = CODE_FLOOR;
    end else if (step_q == '0 || dq_q > UV_W'(CODE_TOP - CODE_FLOOR)) begin
      code_set = CODE_TOP;
    end else begin
      code_set = dq_q[BYTE_W-1:0] + CODE_FLOOR;
    end
  end

  // one restoring division step
  assign rem_sh = {rem_q, dq_q[UV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, step_q};

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= MIN_RST;
      step_q <= STEP_RST;
      mask_q <= MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN:  min_q  <= cfg_wdata_i[MIN_W-1:0];
        CFG_STEP: step_q <= cfg_wdata_i[STEP_W-1:0];
        CFG_MASK: mask_q <= cfg_wdata_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // register bank updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_RAILS; i++) begin
        ctrl_q[i]  <= '0;
        force_q[i] <= '0;
        volt_q[i]  <= '0;
      end
    end else if (cmd_i.apply && rail_ok) begin
      case (kind_q)
        KIND_WRITE: begin
          if (reg_ok) begin
            case (sel_q)
              SEL_CTRL:  ctrl_q[rail_q]  <= wd_q;
              SEL_FORCE: force_q[rail_q] <= wd_q;
              SEL_VOLT:  volt_q[rail_q]  <= wd_q;
              default: ;
            endcase
          end
        end
        KIND_SET: begin
          if (rail_on) begin
            ctrl_q[rail_q] <= ctl_cur & CTL_PIN_CLR;
            volt_q[rail_q] <= code_set;
            if (has_force) begin
              force_q[rail_q] <= code_set & FORCE_CODE_MASK;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // input capture and divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      rail_q  <= rail_i;
      sel_q   <= reg_select_i;
      wd_q    <= write_data_i;
      below_q <= (target_uv_i < UV_W'(min_q));
      dq_q    <= target_uv_i - UV_W'(min_q);
      rem_q   <= '0;
    end else if (cmd_i.div_step) begin
      if (!diff[STEP_W+1]) begin
        rem_q <= diff[STEP_W-1:0];
        dq_q  <= {dq_q[UV_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[STEP_W-1:0];
        dq_q  <= {dq_q[UV_W-2:0], 1'b0};
      end
    end
  end

  // access outcome, then code and step product
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      oor_q <= !rail_ok;
      bad_q <= (kind_q == KIND_RSVD) ||
               ((kind_q == KIND_READ || kind_q == KIND_WRITE) && !reg_ok);
      rd_q  <= (rail_ok && kind_q == KIND_READ && reg_ok) ? reg_byte : '0;
    end
    if (cmd_i.mul) begin
      eff_q  <= oor_q ? '0 : eff;
      st_q   <= (oor_q || bad_q) ? ST_NO_REG : rail_st;
      prod_q <= step_q * vcode;
    end
  end

  assign vcode = (eff & CODE_MASK) - CODE_FLOOR;

  // code to microvolts with range doubling and cap
  always_comb begin
    fv = eff_q & CODE_MASK;
    if (fv == '0) begin
      base = '0;
    end else if (fv <= CODE_FLOOR) begin
      base = BASE_W'(min_q);
    end else if (fv >= CODE_HIGH) begin
      base = BASE_W'(UV_HIGH_CODE);
    end else begin
      base = BASE_W'(min_q) + BASE_W'(prod_q);
    end
    dbl = eff_q[7] ? {base, 1'b0} : {1'b0, base};
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_rd_q   <= rd_q;
      out_st_q   <= st_q;
      out_code_q <= eff_q;
      out_uv_q   <= (dbl > DBL_W'(VMAX_UV)) ? VMAX_UV : dbl[UV_W-1:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = out_rd_q;
  assign status_o         = out_st_q;
  assign effective_code_o = out_code_q;
  assign voltage_uv_o     = out_uv_q;

endmodule

>>> hw/rtl/buck_rail_voltage_select_regs.sv
// Voltage-select register bank of a multi-rail switching regulator.
// Input channel (in_valid_i/in_ready_o) carries one access: read or write of
// a rail's control, force or voltage byte, or a target voltage set.
// Output channel (out_valid_o/out_ready_i) returns one result per access:
// read byte, status, effective select code and output voltage.
// Config port: cfg_we_i writes min (index 0), step (1) or force mask (2);
// write it only while no transaction is in flight.
// Reads and writes step from acceptance through the apply, multiply and done
// states to out_valid_o; a set first runs the bit-serial quotient unit that
// divides the target offset by the step register, one quotient bit per cycle.
// One transaction is processed at a time, and a receiver stall holds the
// current one in the done state.
// Results sit in an output register; a new transaction is accepted while
// a result waits, and finishing holds off until that result is taken.
// Reset clears all rail bytes (every rail off) and loads default config.
module buck_rail_voltage_select_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [brvs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [brvs_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [brvs_pkg::KIND_W-1:0]    kind_i,
  input  logic [brvs_pkg::RAIL_W-1:0]    rail_i,
  input  logic [brvs_pkg::SEL_W-1:0]     reg_select_i,
  input  logic [brvs_pkg::BYTE_W-1:0]    write_data_i,
  input  logic [brvs_pkg::UV_W-1:0]      target_uv_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [brvs_pkg::BYTE_W-1:0]    read_data_o,
  output logic [brvs_pkg::STAT_W-1:0]    status_o,
  output logic [brvs_pkg::BYTE_W-1:0]    effective_code_o,
  output logic [brvs_pkg::UV_W-1:0]      voltage_uv_o
);
  import brvs_pkg::*;

  `include "buck_rail_voltage_select_regs_assert.svh"

  brvs_cmd_t cmd;
  brvs_sts_t sts;
  logic      off_or_pin;

  // sequencer
  brvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // register bank, divider and voltage arithmetic
  brvs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .kind_i           (kind_i),
    .rail_i           (rail_i),
    .reg_select_i     (reg_select_i),
    .write_data_i     (write_data_i),
    .target_uv_i      (target_uv_i),
    .out_ready_i      (out_ready_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .read_data_o      (read_data_o),
    .status_o         (status_o),
    .effective_code_o (effective_code_o),
    .voltage_uv_o     (voltage_uv_o)
  );

  // result reports a rail that is off or under pin control
  assign off_or_pin = out_valid_o && (status_o == ST_OFF || status_o == ST_PIN);

  // one transaction in flight at a time
  `BRVS_ASSERT_NEXT(a_single_txn, in_valid_i && in_ready_o, !in_ready_o)

  // an off or pin-controlled rail reports no code and no voltage
  `BRVS_ASSERT_NOW(a_off_zero, off_or_pin, effective_code_o == '0 && voltage_uv_o == '0)

  // reported voltage never exceeds the cap
  `BRVS_ASSERT_NOW(a_volt_cap, out_valid_o, voltage_uv_o <= VMAX_UV)

endmodule
